// ===== rtl/fsp_pkg.sv =====
// ============================================================================
// Format spec parser package
// Shared types, codes and arithmetic helpers of the conversion spec parser.
// ============================================================================
package fsp_pkg;

    localparam int unsigned NUM_BITS = 16;
    localparam logic [NUM_BITS-1:0] NUM_MAX = '1;

    typedef enum logic [2:0] {
        ST_FLAGS,
        ST_WIDTH,
        ST_WDIG,
        ST_DOT,
        ST_PREC,
        ST_PDIG,
        ST_MOD,
        ST_MOD2
    } t_stage;

    typedef enum logic [2:0] {
        MOD_NONE,
        MOD_HH,
        MOD_H,
        MOD_L,
        MOD_LL,
        MOD_CAPL
    } t_mod;

    typedef enum logic [1:0] {
        STS_OK,
        STS_NO_SPEC,
        STS_UNKNOWN
    } t_status;

    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    localparam logic [1:0] FS_NONE = 2'd0;
    localparam logic [1:0] FS_F    = 2'd1;
    localparam logic [1:0] FS_E    = 2'd2;
    localparam logic [1:0] FS_G    = 2'd3;

    localparam logic [4:0] AT_NONE    = 5'd0;
    localparam logic [4:0] AT_INT     = 5'd1;
    localparam logic [4:0] AT_UINT    = 5'd6;
    localparam logic [4:0] AT_DOUBLE  = 5'd11;
    localparam logic [4:0] AT_LDOUBLE = 5'd12;
    localparam logic [4:0] AT_CHAR    = 5'd13;
    localparam logic [4:0] AT_WCHAR   = 5'd14;
    localparam logic [4:0] AT_STR     = 5'd15;
    localparam logic [4:0] AT_WSTR    = 5'd16;
    localparam logic [4:0] AT_PTR     = 5'd17;
    localparam logic [4:0] AT_PCT     = 5'd18;
    localparam logic [4:0] AT_N_INT   = 5'd19;

    localparam logic [4:0] FLG_LEFT  = 5'b00001;
    localparam logic [4:0] FLG_SIGN  = 5'b00010;
    localparam logic [4:0] FLG_BLANK = 5'b00100;
    localparam logic [4:0] FLG_ALT   = 5'b01000;
    localparam logic [4:0] FLG_ZPAD  = 5'b10000;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_HASH  = "#";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CH_UP_Z  = "Z";
    localparam logic [7:0] CH_UP_L  = "L";
    localparam logic [7:0] CH_LO_H  = "h";
    localparam logic [7:0] CH_LO_L  = "l";
    localparam logic [7:0] CH_LO_D  = "d";
    localparam logic [7:0] CH_LO_I  = "i";
    localparam logic [7:0] CH_LO_U  = "u";
    localparam logic [7:0] CH_LO_O  = "o";
    localparam logic [7:0] CH_LO_X  = "x";
    localparam logic [7:0] CH_LO_F  = "f";
    localparam logic [7:0] CH_LO_E  = "e";
    localparam logic [7:0] CH_LO_G  = "g";
    localparam logic [7:0] CH_LO_C  = "c";
    localparam logic [7:0] CH_LO_S  = "s";
    localparam logic [7:0] CH_LO_P  = "p";
    localparam logic [7:0] CH_LO_N  = "n";
    localparam logic [7:0] CH_PCT   = "%";
    localparam logic [7:0] CASE_OFS = 8'd32;

    typedef struct packed {
        logic [7:0]         ch;
        logic signed [31:0] star_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  flag_bits;
        logic        width_given;
        logic [15:0] width_num;
        logic        precision_given;
        logic [15:0] prec_num;
        logic [2:0]  length_modifier;
        logic [7:0]  specifier_char;
        logic        uppercase;
        logic [4:0]  arg_type;
        logic [1:0]  number_base;
        logic [1:0]  float_style;
    } t_out_item;

    function automatic logic [4:0] flag_of(input logic [7:0] c);
        logic [4:0] f;
        unique case (c)
            CH_MINUS: f = FLG_LEFT;
            CH_PLUS:  f = FLG_SIGN;
            CH_SPACE: f = FLG_BLANK;
            CH_HASH:  f = FLG_ALT;
            CH_ZERO:  f = FLG_ZPAD;
            default:  f = 5'd0;
        endcase
        return f;
    endfunction

    function automatic logic [4:0] int_kind(input t_mod m);
        logic [4:0] k;
        unique case (m)
            MOD_HH:  k = 5'd1;
            MOD_H:   k = 5'd2;
            MOD_L:   k = 5'd3;
            MOD_LL:  k = 5'd4;
            default: k = 5'd0;
        endcase
        return k;
    endfunction

    function automatic logic [NUM_BITS-1:0] add_digit(
        input logic [NUM_BITS-1:0] acc,
        input logic [7:0]          c
    );
        logic [NUM_BITS+3:0] sum;
        sum = (NUM_BITS+4)'({acc, 3'b000}) + (NUM_BITS+4)'({acc, 1'b0})
            + (NUM_BITS+4)'(c - CH_ZERO);
        if (sum > (NUM_BITS+4)'(NUM_MAX)) begin
            return NUM_MAX;
        end
        return sum[NUM_BITS-1:0];
    endfunction

    function automatic logic [NUM_BITS-1:0] mag_of(input logic signed [31:0] sv);
        logic [31:0] u;
        logic [31:0] m;
        u = sv;
        m = u[31] ? (32'd0 - u) : u;
        if ({1'b0, m} > 33'(NUM_MAX)) begin
            return NUM_MAX;
        end
        return m[NUM_BITS-1:0];
    endfunction

endpackage

// ===== rtl/format_spec_parser.sv =====
// ============================================================================
// Format spec parser
// Walks the characters after a percent sign and emits one record per spec.
// Timing: input register, then parse logic into the result register.
// Throughput: one character per cycle, held while a finished spec waits on
//   a full result register; the stage and accumulator update through one
//   digit multiply-add sets the cycle.
// Reset: synchronous active low; parse state returns to the flags stage,
//   scan mode clears to print grammar, both registers empty.
// ============================================================================
module format_spec_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fsp_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fsp_pkg::t_out_item   o_out_data
);
    import fsp_pkg::*;

    logic                r_scan_mode;
    logic                r_in_valid;
    t_in_item            r_in;
    logic                r_out_valid;
    t_out_item           r_out;

    t_stage              r_stage,  n_stage;
    logic [4:0]          r_flags,  n_flags;
    logic                r_wseen,  n_wseen;
    logic [NUM_BITS-1:0] r_wacc,   n_wacc;
    logic                r_pseen,  n_pseen;
    logic [NUM_BITS-1:0] r_pacc,   n_pacc;
    t_mod                r_mod,    n_mod;

    logic                emit;
    logic                advance;
    t_out_item           rec;

    logic [7:0]          ch;
    logic [7:0]          lc;
    logic                upper;
    logic                is_dig;
    logic [4:0]          fbit;
    logic [4:0]          kind;
    logic [NUM_BITS-1:0] w_add;
    logic [NUM_BITS-1:0] p_add;
    logic [NUM_BITS-1:0] mag;

    assign ch     = r_in.ch;
    assign fbit   = flag_of(ch);
    assign is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign w_add  = add_digit(r_wacc, ch);
    assign p_add  = add_digit(r_pacc, ch);
    assign mag    = mag_of(r_in.star_value);
    assign upper  = (ch >= CH_UP_A) && (ch <= CH_UP_Z);
    assign lc     = upper ? (ch + CASE_OFS) : ch;
    assign kind   = int_kind(r_mod);

    // stage walk: fall through stages until the character is taken or ends the spec
    always_comb begin
        logic   taken;
        t_stage st;
        taken   = 1'b0;
        emit    = 1'b0;
        st      = r_stage;
        n_stage = r_stage;
        n_flags = r_flags;
        n_wseen = r_wseen;
        n_wacc  = r_wacc;
        n_pseen = r_pseen;
        n_pacc  = r_pacc;
        n_mod   = r_mod;

        if (st == ST_FLAGS) begin
            if (!r_scan_mode && (fbit != 5'd0) && ((r_flags & fbit) == 5'd0)) begin
                n_flags = r_flags | fbit;
                taken   = 1'b1;
            end else begin
                st = ST_WIDTH;
            end
        end
        if (!taken && st == ST_WIDTH) begin
            if (ch == CH_STAR) begin
                n_wseen = 1'b1;
                n_wacc  = r_scan_mode ? '0 : mag;
                n_stage = r_scan_mode ? ST_MOD : ST_DOT;
                taken   = 1'b1;
            end else if (is_dig) begin
                n_wseen = 1'b1;
                n_wacc  = w_add;
                n_stage = ST_WDIG;
                taken   = 1'b1;
            end else begin
                st = ST_DOT;
            end
        end
        if (!taken && st == ST_WDIG) begin
            if (is_dig) begin
                n_wacc = w_add;
                taken  = 1'b1;
            end else begin
                st = ST_DOT;
            end
        end
        if (!taken && st == ST_DOT) begin
            if (!r_scan_mode && ch == CH_DOT) begin
                n_pseen = 1'b1;
                n_stage = ST_PREC;
                taken   = 1'b1;
            end else begin
                st = ST_MOD;
            end
        end
        if (!taken && st == ST_PREC) begin
            if (ch == CH_STAR) begin
                n_pacc  = mag;
                n_stage = ST_MOD;
                taken   = 1'b1;
            end else if (is_dig) begin
                n_pacc  = p_add;
                n_stage = ST_PDIG;
                taken   = 1'b1;
            end else begin
                st = ST_MOD;
            end
        end
        if (!taken && st == ST_PDIG) begin
            if (is_dig) begin
                n_pacc = p_add;
                taken  = 1'b1;
            end else begin
                st = ST_MOD;
            end
        end
        if (!taken && st == ST_MOD) begin
            if (ch == CH_LO_H || ch == CH_LO_L || ch == CH_UP_L) begin
                n_mod   = (ch == CH_LO_H) ? MOD_H : (ch == CH_LO_L) ? MOD_L : MOD_CAPL;
                n_stage = ST_MOD2;
                taken   = 1'b1;
            end else begin
                emit = 1'b1;
            end
        end else if (!taken && st == ST_MOD2) begin
            if (r_mod == MOD_H && ch == CH_LO_H) begin
                n_mod = MOD_HH;
                taken = 1'b1;
            end else if (r_mod == MOD_L && ch == CH_LO_L) begin
                n_mod = MOD_LL;
                taken = 1'b1;
            end else begin
                emit = 1'b1;
            end
        end

        if (emit) begin
            n_stage = ST_FLAGS;
            n_flags = '0;
            n_wseen = 1'b0;
            n_wacc  = '0;
            n_pseen = 1'b0;
            n_pacc  = '0;
            n_mod   = MOD_NONE;
        end
    end

    // result record, built from the state the spec ended in
    always_comb begin
        rec.status          = STS_OK;
        rec.flag_bits       = r_flags;
        rec.width_given     = r_wseen;
        rec.width_num       = 16'(r_wacc);
        rec.precision_given = r_pseen;
        rec.prec_num        = 16'(r_pacc);
        rec.length_modifier = r_mod;
        rec.specifier_char  = ch;
        rec.uppercase       = upper;
        rec.arg_type        = AT_NONE;
        rec.number_base     = BASE_DEC;
        rec.float_style     = FS_NONE;
        if (ch == CH_NUL) begin
            rec.status = STS_NO_SPEC;
        end else begin
            unique case (lc)
                CH_LO_D, CH_LO_I: begin
                    rec.arg_type  = AT_INT + kind;
                    rec.flag_bits = r_flags & ~FLG_ALT;
                end
                CH_LO_U: begin
                    rec.arg_type  = AT_UINT + kind;
                    rec.flag_bits = r_flags & ~FLG_ALT;
                end
                CH_LO_O: begin
                    rec.arg_type    = AT_UINT + kind;
                    rec.number_base = BASE_OCT;
                end
                CH_LO_X: begin
                    rec.arg_type    = AT_UINT + kind;
                    rec.number_base = BASE_HEX;
                end
                CH_LO_F, CH_LO_E, CH_LO_G: begin
                    rec.arg_type    = (r_mod == MOD_CAPL) ? AT_LDOUBLE : AT_DOUBLE;
                    rec.float_style = (lc == CH_LO_F) ? FS_F : (lc == CH_LO_E) ? FS_E : FS_G;
                end
                CH_LO_C: begin
                    rec.arg_type  = (r_mod == MOD_L) ? AT_WCHAR : AT_CHAR;
                    rec.flag_bits = r_flags & FLG_LEFT;
                end
                CH_LO_S: begin
                    rec.arg_type  = (r_mod == MOD_L) ? AT_WSTR : AT_STR;
                    rec.flag_bits = r_flags & FLG_LEFT;
                end
                CH_LO_P: begin
                    rec.arg_type    = AT_PTR;
                    rec.number_base = BASE_HEX;
                    rec.flag_bits   = r_flags & ~(FLG_SIGN | FLG_BLANK | FLG_ALT);
                end
                CH_PCT: begin
                    rec.arg_type = AT_PCT;
                end
                CH_LO_N: begin
                    rec.arg_type = AT_N_INT + kind;
                end
                default: begin
                    rec.status = STS_UNKNOWN;
                end
            endcase
        end
    end

    assign advance    = r_in_valid && (!emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_mode <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_stage     <= ST_FLAGS;
            r_flags     <= '0;
            r_wseen     <= 1'b0;
            r_wacc      <= '0;
            r_pseen     <= 1'b0;
            r_pacc      <= '0;
            r_mod       <= MOD_NONE;
        end else begin
            if (i_cfg_we) begin
                r_scan_mode <= i_cfg_data;
            end
            r_in_valid  <= (i_in_valid && o_in_ready) || (r_in_valid && !advance);
            r_out_valid <= (r_out_valid && !i_out_ready) || (advance && emit);
            if (advance) begin
                r_stage <= n_stage;
                r_flags <= n_flags;
                r_wseen <= n_wseen;
                r_wacc  <= n_wacc;
                r_pseen <= n_pseen;
                r_pacc  <= n_pacc;
                r_mod   <= n_mod;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (advance && emit) begin
            r_out <= rec;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_in_valid)
        else $error("result valid right after reset");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && emit |=> r_stage == ST_FLAGS && r_flags == 5'd0 && !r_wseen
            && !r_pseen && r_mod == MOD_NONE)
        else $error("parse state not cleared after record");

    a_ok_has_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STS_OK |-> o_out_data.arg_type != AT_NONE)
        else $error("ok record without argument type");

    a_err_no_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != STS_OK |-> o_out_data.arg_type == AT_NONE
            && o_out_data.number_base == BASE_DEC && o_out_data.float_style == FS_NONE)
        else $error("error record carries conversion fields");

    a_prec_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.precision_given |-> o_out_data.prec_num == 16'd0)
        else $error("precision value without dot");
`endif

endmodule

// ===== tb/format_spec_parser_tb.sv =====
// ============================================================================
// format_spec_parser testbench
// Streams conversion spec characters through the parser in print and scan
// grammar, predicts every emitted record in a scoreboard, and compares each
// record field by field under random valid/ready idling on both sides.
// ============================================================================
`timescale 1ns / 1ps

module format_spec_parser_tb;
    import fsp_pkg::*;

    class fmt_spec_book;
        bit          scan_on;
        t_stage      stage;
        logic [4:0]  flags;
        bit          w_seen;
        int unsigned w_acc;
        bit          p_seen;
        int unsigned p_acc;
        t_mod        modc;
        t_out_item   due_records[$];
        int          bad_count;
        int          record_count;

        function new();
            scan_on      = 1'b0;
            bad_count    = 0;
            record_count = 0;
            restart();
        endfunction

        function void restart();
            stage  = ST_FLAGS;
            flags  = '0;
            w_seen = 1'b0;
            w_acc  = 0;
            p_seen = 1'b0;
            p_acc  = 0;
            modc   = MOD_NONE;
        endfunction

        function int pending();
            return due_records.size();
        endfunction

        function int unsigned clamp_num(longint v);
            if (v > longint'(NUM_MAX)) begin
                return 32'(NUM_MAX);
            end
            return 32'(v);
        endfunction

        function int unsigned push_digit(int unsigned acc, logic [7:0] c);
            return clamp_num(longint'(acc) * 10 + longint'(c) - longint'(CH_ZERO));
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function logic [4:0] flag_bit(logic [7:0] c);
            if (c == CH_MINUS) return FLG_LEFT;
            if (c == CH_PLUS)  return FLG_SIGN;
            if (c == CH_SPACE) return FLG_BLANK;
            if (c == CH_HASH)  return FLG_ALT;
            if (c == CH_ZERO)  return FLG_ZPAD;
            return 5'd0;
        endfunction

        function logic [4:0] size_step(t_mod m);
            case (m)
                MOD_HH:  return 5'd1;
                MOD_H:   return 5'd2;
                MOD_L:   return 5'd3;
                MOD_LL:  return 5'd4;
                default: return 5'd0;
            endcase
        endfunction

        function void close_spec(logic [7:0] c);
            t_out_item  r;
            logic [7:0] lc;
            logic [4:0] kind;
            r = '0;
            r.flag_bits       = flags;
            r.width_given     = w_seen;
            r.width_num       = w_acc[15:0];
            r.precision_given = p_seen;
            r.prec_num        = p_acc[15:0];
            r.length_modifier = modc;
            r.specifier_char  = c;
            r.number_base     = BASE_DEC;
            r.float_style     = FS_NONE;
            r.arg_type        = AT_NONE;
            if (c == CH_NUL) begin
                r.status = STS_NO_SPEC;
            end else begin
                r.status    = STS_OK;
                r.uppercase = (c >= CH_UP_A && c <= CH_UP_Z);
                lc   = r.uppercase ? c + CASE_OFS : c;
                kind = size_step(modc);
                case (lc)
                    CH_LO_D, CH_LO_I: begin
                        r.arg_type  = AT_INT + kind;
                        r.flag_bits &= ~FLG_ALT;
                    end
                    CH_LO_U: begin
                        r.arg_type  = AT_UINT + kind;
                        r.flag_bits &= ~FLG_ALT;
                    end
                    CH_LO_O: begin
                        r.arg_type    = AT_UINT + kind;
                        r.number_base = BASE_OCT;
                    end
                    CH_LO_X: begin
                        r.arg_type    = AT_UINT + kind;
                        r.number_base = BASE_HEX;
                    end
                    CH_LO_F, CH_LO_E, CH_LO_G: begin
                        r.arg_type    = (modc == MOD_CAPL) ? AT_LDOUBLE : AT_DOUBLE;
                        r.float_style = (lc == CH_LO_F) ? FS_F : (lc == CH_LO_E) ? FS_E : FS_G;
                    end
                    CH_LO_C: begin
                        r.arg_type  = (modc == MOD_L) ? AT_WCHAR : AT_CHAR;
                        r.flag_bits &= FLG_LEFT;
                    end
                    CH_LO_S: begin
                        r.arg_type  = (modc == MOD_L) ? AT_WSTR : AT_STR;
                        r.flag_bits &= FLG_LEFT;
                    end
                    CH_LO_P: begin
                        r.arg_type    = AT_PTR;
                        r.number_base = BASE_HEX;
                        r.flag_bits   &= ~(FLG_SIGN | FLG_BLANK | FLG_ALT);
                    end
                    CH_PCT:  r.arg_type = AT_PCT;
                    CH_LO_N: r.arg_type = AT_N_INT + kind;
                    default: begin
                        r.status = STS_UNKNOWN;
                    end
                endcase
            end
            due_records.push_back(r);
            restart();
        endfunction

        // advance the parse state by one transfer; a finished spec queues a record
        function void take_char(t_in_item it);
            logic [7:0]  c;
            logic [4:0]  fb;
            longint      sv;
            int unsigned mag;
            bit          busy;
            c    = it.ch;
            sv   = $signed(it.star_value);
            mag  = clamp_num(sv < 0 ? -sv : sv);
            busy = 1'b1;
            while (busy) begin
                case (stage)
                    ST_FLAGS: begin
                        fb = flag_bit(c);
                        if (!scan_on && fb != 0 && (flags & fb) == 0) begin
                            flags |= fb;
                            busy = 1'b0;
                        end else begin
                            stage = ST_WIDTH;
                        end
                    end
                    ST_WIDTH: begin
                        if (c == CH_STAR) begin
                            w_seen = 1'b1;
                            w_acc  = scan_on ? 0 : mag;
                            stage  = scan_on ? ST_MOD : ST_DOT;
                            busy   = 1'b0;
                        end else if (is_num(c)) begin
                            w_seen = 1'b1;
                            w_acc  = push_digit(w_acc, c);
                            stage  = ST_WDIG;
                            busy   = 1'b0;
                        end else begin
                            stage = ST_DOT;
                        end
                    end
                    ST_WDIG: begin
                        if (is_num(c)) begin
                            w_acc = push_digit(w_acc, c);
                            busy  = 1'b0;
                        end else begin
                            stage = ST_DOT;
                        end
                    end
                    ST_DOT: begin
                        if (!scan_on && c == CH_DOT) begin
                            p_seen = 1'b1;
                            stage  = ST_PREC;
                            busy   = 1'b0;
                        end else begin
                            stage = ST_MOD;
                        end
                    end
                    ST_PREC: begin
                        if (c == CH_STAR) begin
                            p_acc = mag;
                            stage = ST_MOD;
                            busy  = 1'b0;
                        end else if (is_num(c)) begin
                            p_acc = push_digit(p_acc, c);
                            stage = ST_PDIG;
                            busy  = 1'b0;
                        end else begin
                            stage = ST_MOD;
                        end
                    end
                    ST_PDIG: begin
                        if (is_num(c)) begin
                            p_acc = push_digit(p_acc, c);
                            busy  = 1'b0;
                        end else begin
                            stage = ST_MOD;
                        end
                    end
                    ST_MOD: begin
                        if (c == CH_LO_H || c == CH_LO_L || c == CH_UP_L) begin
                            modc  = (c == CH_LO_H) ? MOD_H : (c == CH_LO_L) ? MOD_L : MOD_CAPL;
                            stage = ST_MOD2;
                        end else begin
                            close_spec(c);
                        end
                        busy = 1'b0;
                    end
                    default: begin
                        if (modc == MOD_H && c == CH_LO_H) begin
                            modc = MOD_HH;
                        end else if (modc == MOD_L && c == CH_LO_L) begin
                            modc = MOD_LL;
                        end else begin
                            close_spec(c);
                        end
                        busy = 1'b0;
                    end
                endcase
            end
        endfunction

        function void field_check(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t  %s: expected %0d, got %0d", $time, name, want, got);
                bad_count++;
            end
        endfunction

        function void match_record(t_out_item g);
            t_out_item e;
            if (due_records.size() == 0) begin
                $display("%0t  record: expected none, got %h", $time, g);
                bad_count++;
            end else begin
                e = due_records.pop_front();
                record_count++;
                field_check("status", e.status, g.status);
                field_check("flag_bits", e.flag_bits, g.flag_bits);
                field_check("width_given", e.width_given, g.width_given);
                field_check("width_num", e.width_num, g.width_num);
                field_check("precision_given", e.precision_given, g.precision_given);
                field_check("prec_num", e.prec_num, g.prec_num);
                field_check("length_modifier", e.length_modifier, g.length_modifier);
                field_check("specifier_char", e.specifier_char, g.specifier_char);
                field_check("uppercase", e.uppercase, g.uppercase);
                field_check("arg_type", e.arg_type, g.arg_type);
                field_check("number_base", e.number_base, g.number_base);
                field_check("float_style", e.float_style, g.float_style);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 228;
    localparam int HOLD_CYCLES = 80;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_data;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;

    fmt_spec_book book = new();
    int  items_sent  = 0;
    int  mode_writes = 0;
    int  cycle_count = 0;
    bit  lazy_tx     = 1'b0;
    bit  lazy_rx     = 1'b0;
    bit  hold_out    = 1'b0;

    format_spec_parser uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [31:0] pick_star();
        case ($urandom_range(0, 5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return $signed($urandom_range(0, 200)) - 32'sd100;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_char(input logic [7:0] c, input logic signed [31:0] sv);
        t_in_item it;
        int       gap;
        it.ch         = c;
        it.star_value = sv;
        gap = lazy_tx ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        book.take_char(it);
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic signed [31:0] sv);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], sv);
        end
    endtask

    // drop valid, drain all records, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_scan_mode(input bit v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        book.scan_on = v;
        mode_writes++;
    endtask

    task automatic send_random_spec();
        string      specs;
        string      fl;
        logic [7:0] c;
        int         n;
        int         k;
        specs = "diuoxfegcsp%n";
        fl    = "-+ #0";
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)), pick_star());
        end else begin
            if (!book.scan_on) begin
                repeat ($urandom_range(0, 3)) send_char(fl[$urandom_range(0, 4)], pick_star());
            end
            case ($urandom_range(0, 3))
                1: begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
                    repeat (n) send_char(CH_ZERO + 8'($urandom_range(0, 9)), pick_star());
                end
                2: send_char(CH_STAR, pick_star());
                default: ;
            endcase
            if (!book.scan_on) begin
                k = $urandom_range(0, 3);
                if (k != 0) begin
                    send_char(CH_DOT, pick_star());
                end
                if (k == 2) begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
                    repeat (n) send_char(CH_ZERO + 8'($urandom_range(0, 9)), pick_star());
                end else if (k == 3) begin
                    send_char(CH_STAR, pick_star());
                end
            end
            case ($urandom_range(0, 7))
                1: send_text("h", pick_star());
                2: send_text("hh", pick_star());
                3: send_text("l", pick_star());
                4: send_text("ll", pick_star());
                5: send_text("L", pick_star());
                6: send_text($urandom_range(0, 1) ? "hhh" : "lll", pick_star());
                default: ;
            endcase
            k = $urandom_range(0, 99);
            if (k < 80) begin
                c = specs[$urandom_range(0, specs.len() - 1)];
                if (c != CH_PCT && $urandom_range(0, 3) == 0) begin
                    c = c - CASE_OFS;
                end
            end else if (k < 88) begin
                c = CH_NUL;
            end else begin
                c = 8'($urandom_range(0, 255));
            end
            send_char(c, pick_star());
        end
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("format_spec_parser_tb NOT OK");
        $finish;
    end

    initial begin : drain
        int gap;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_out) begin
                hold_out = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = lazy_rx ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            book.match_record(out_data);
        end
    end

    initial begin : stimulus
        int goal;
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_data <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_scan_mode(1'b0);
        // all flags, star width at the negative extreme, star precision at the max
        send_text("-+ #0*", 32'sh8000_0000);
        send_text(".*hhd", 32'sh7fff_ffff);
        // repeated zero flag turns into a width digit; width saturates
        send_text("0070000Lg", 32'sd0);
        // third h after a doubled modifier ends the spec as unknown
        send_text("hhh", 32'sd0);
        send_char(CH_NUL, 32'sd0);
        // switch grammar in the middle of the precision digits
        send_text(".5", 32'sd0);
        settle();
        set_scan_mode(1'b1);
        send_text("3n", 32'sd0);
        send_text("*s", -32'sd9);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            set_scan_mode((ph < 2) ? ph[0] : 1'($urandom_range(0, 1)));
            lazy_tx = $urandom_range(0, 3) != 0;
            lazy_rx = $urandom_range(0, 3) != 0;
            if (ph == 3) begin
                lazy_tx  = 1'b0;
                hold_out = 1'b1;
            end
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) send_random_spec();
            settle();
        end

        $display("Sent %0d characters over %0d grammar settings, with random idling",
                 items_sent, mode_writes);
        $display("and one long output stall; %0d records compared, %0d field mismatches.",
                 book.record_count, book.bad_count);
        if (book.bad_count == 0 && book.pending() == 0) begin
            $display("format_spec_parser_tb OK");
        end else begin
            $display("format_spec_parser_tb NOT OK");
        end
        $finish;
    end

endmodule
